// ===== rtl/lcu_pkg.sv =====
// -----------------------------------------------------------------------------
// lcu_pkg
// Shared types, sizes and fixed-point helpers of the LSTM cell update unit.
// -----------------------------------------------------------------------------
package lcu_pkg;

  // defaults for the sequence geometry
  localparam int unsigned HiddenMaxDefault = 256;
  localparam int unsigned BatchMaxDefault  = 8;

  // index range of the state store
  localparam int unsigned IdxWidth  = 11;
  localparam int unsigned IdxSpace  = 2048;
  localparam int unsigned DataWidth = 16;

  // one input request as seen by the pipeline
  typedef struct packed {
    logic                        first_step;
    logic                        active;
    logic [IdxWidth-1:0]         entry_index;
    logic signed [DataWidth-1:0] init_h;
    logic signed [DataWidth-1:0] init_c;
    logic signed [DataWidth-1:0] gate_i;
    logic signed [DataWidth-1:0] gate_o;
    logic signed [DataWidth-1:0] gate_f;
    logic signed [DataWidth-1:0] gate_c;
    logic signed [DataWidth-1:0] peep_i;
    logic signed [DataWidth-1:0] peep_o;
    logic signed [DataWidth-1:0] peep_f;
  } in_req_t;

  // control that travels with a request down the pipeline
  typedef struct packed {
    logic                        active;
    logic                        wr;
    logic [IdxWidth-1:0]         idx;
    logic signed [DataWidth-1:0] h_prev;
    logic signed [DataWidth-1:0] c_prev;
  } ctl_t;

  // store read port
  typedef struct packed {
    logic                en;
    logic [IdxWidth-1:0] idx;
  } rd_req_t;

  // store write port
  typedef struct packed {
    logic                        en;
    logic [IdxWidth-1:0]         idx;
    logic signed [DataWidth-1:0] c;
    logic signed [DataWidth-1:0] h;
  } wr_req_t;

  // saturate to 16 bits
  function automatic logic signed [15:0] sat16(logic signed [23:0] v);
    if (v > 24'sd32767) return 16'sh7fff;
    if (v < -24'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // q5.10 product scaling, rounded half up
  function automatic logic signed [21:0] qround(logic signed [31:0] p);
    logic signed [31:0] t;
    t = p + 32'sd512;
    return t[31:10];
  endfunction

  // gate plus saturated peephole product
  function automatic logic signed [15:0] peep_add(logic signed [15:0] gate,
                                                  logic signed [31:0] prod);
    logic signed [23:0] s;
    s = 24'(gate) + 24'(sat16(24'(qround(prod))));
    return sat16(s);
  endfunction

  // sigmoid knots at -8..8
  function automatic logic signed [11:0] sig_knot(logic [4:0] k);
    unique case (k)
      5'd0:    return 12'sd0;
      5'd1:    return 12'sd1;
      5'd2:    return 12'sd3;
      5'd3:    return 12'sd7;
      5'd4:    return 12'sd18;
      5'd5:    return 12'sd49;
      5'd6:    return 12'sd122;
      5'd7:    return 12'sd275;
      5'd8:    return 12'sd512;
      5'd9:    return 12'sd749;
      5'd10:   return 12'sd902;
      5'd11:   return 12'sd975;
      5'd12:   return 12'sd1006;
      5'd13:   return 12'sd1017;
      5'd14:   return 12'sd1021;
      5'd15:   return 12'sd1023;
      default: return 12'sd1024;
    endcase
  endfunction

  // tanh knots at -4..4 in half steps
  function automatic logic signed [11:0] tanh_knot(logic [4:0] k);
    unique case (k)
      5'd0:    return -12'sd1024;
      5'd1:    return -12'sd1022;
      5'd2:    return -12'sd1019;
      5'd3:    return -12'sd1010;
      5'd4:    return -12'sd987;
      5'd5:    return -12'sd927;
      5'd6:    return -12'sd780;
      5'd7:    return -12'sd473;
      5'd8:    return 12'sd0;
      5'd9:    return 12'sd473;
      5'd10:   return 12'sd780;
      5'd11:   return 12'sd927;
      5'd12:   return 12'sd987;
      5'd13:   return 12'sd1010;
      5'd14:   return 12'sd1019;
      5'd15:   return 12'sd1022;
      default: return 12'sd1024;
    endcase
  endfunction

  // piecewise linear sigmoid
  function automatic logic signed [15:0] sig_q(logic signed [15:0] x);
    logic signed [16:0] u;
    logic [3:0]         k;
    logic [9:0]         fr;
    logic [11:0]        d;
    logic [21:0]        m;
    if (x <= -16'sd8192) return 16'sd0;
    if (x >= 16'sd8192) return 16'sd1024;
    u  = 17'(x) + 17'sd8192;
    k  = u[13:10];
    fr = u[9:0];
    d  = 12'(sig_knot(5'({1'b0, k}) + 5'd1) - sig_knot({1'b0, k}));
    m  = 22'(d) * 22'(fr) + 22'd512;
    return 16'(sig_knot({1'b0, k})) + 16'({4'b0, m[21:10]});
  endfunction

  // piecewise linear tanh
  function automatic logic signed [15:0] tanh_q(logic signed [15:0] x);
    logic signed [16:0] u;
    logic [3:0]         k;
    logic [8:0]         fr;
    logic [11:0]        d;
    logic [20:0]        m;
    if (x <= -16'sd4096) return -16'sd1024;
    if (x >= 16'sd4096) return 16'sd1024;
    u  = 17'(x) + 17'sd4096;
    k  = u[12:9];
    fr = u[8:0];
    d  = 12'(tanh_knot(5'({1'b0, k}) + 5'd1) - tanh_knot({1'b0, k}));
    m  = 21'(d) * 21'(fr) + 21'd256;
    return 16'(tanh_knot({1'b0, k})) + 16'({4'b0, m[20:9]});
  endfunction

endpackage

// ===== rtl/lcu_store.sv =====
// -----------------------------------------------------------------------------
// lcu_store
// Cell and hidden state memories, one synchronous read and one write port.
// -----------------------------------------------------------------------------
module lcu_store #(
  parameter int unsigned HiddenMax = lcu_pkg::HiddenMaxDefault,
  parameter int unsigned BatchMax  = lcu_pkg::BatchMaxDefault
) (
  input  logic                   clk_i,
  input  lcu_pkg::rd_req_t       rd_i,
  input  lcu_pkg::wr_req_t       wr_i,
  output logic signed [15:0]     rd_c_o,
  output logic signed [15:0]     rd_h_o
);

  localparam int unsigned EntryCount = HiddenMax * BatchMax;
  localparam int unsigned Depth =
    (EntryCount < lcu_pkg::IdxSpace) ? EntryCount : lcu_pkg::IdxSpace;
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;

  logic signed [15:0] cell_mem   [Depth];
  logic signed [15:0] hidden_mem [Depth];
  logic [AddrWidth-1:0] rd_addr;
  logic [AddrWidth-1:0] wr_addr;

  assign rd_addr = rd_i.idx[AddrWidth-1:0];
  assign wr_addr = wr_i.idx[AddrWidth-1:0];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      cell_mem[wr_addr]   <= wr_i.c;
      hidden_mem[wr_addr] <= wr_i.h;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_c_o <= cell_mem[rd_addr];
      rd_h_o <= hidden_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lcu_pipe.sv =====
// -----------------------------------------------------------------------------
// lcu_pipe
// Elastic gate pipeline: state read, peepholes, activations, cell and hidden
// update, write-back and output register, with a read-after-write interlock.
// -----------------------------------------------------------------------------
module lcu_pipe #(
  parameter int unsigned HiddenMax = lcu_pkg::HiddenMaxDefault,
  parameter int unsigned BatchMax  = lcu_pkg::BatchMaxDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 use_peephole_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lcu_pkg::in_req_t     in_req_i,
  output lcu_pkg::rd_req_t     rd_o,
  input  logic signed [15:0]   rd_c_i,
  input  logic signed [15:0]   rd_h_i,
  output lcu_pkg::wr_req_t     wr_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   h_out_o,
  output logic signed [15:0]   c_out_o,
  output logic signed [15:0]   y_out_o
);

  localparam int unsigned EntryCount = HiddenMax * BatchMax;
  localparam int unsigned NumStages  = 9;

  logic [NumStages:1]   v_q;
  logic [NumStages+1:1] en;
  logic                 out_valid_q;
  logic                 accept;
  logic                 hazard;
  logic                 in_range;

  // stage 1: request as read from the store
  lcu_pkg::in_req_t s1_q;
  logic             s1_range_q;
  // control per stage from stage 2 on
  lcu_pkg::ctl_t    ctl_q [2:NumStages];
  lcu_pkg::ctl_t    s1_ctl;

  logic signed [15:0] s2_gi_q, s2_gf_q, s2_go_q, s2_gc_q, s2_po_q;
  logic signed [31:0] s2_pi_q, s2_pf_q;
  logic signed [15:0] s3_gi_q, s3_gf_q, s3_go_q, s3_gc_q, s3_po_q;
  logic signed [15:0] s4_it_q, s4_ft_q, s4_ct_q, s4_go_q, s4_po_q;
  logic signed [31:0] s5_fc_q, s5_ig_q;
  logic signed [15:0] s5_go_q, s5_po_q;
  logic signed [15:0] s6_cn_q, s6_go_q, s6_po_q;
  logic signed [15:0] s7_cn_q, s7_go_q;
  logic signed [31:0] s7_po_q;
  logic signed [15:0] s8_cn_q, s8_go_q;
  logic signed [15:0] s9_cn_q, s9_ot_q, s9_tc_q;
  logic signed [15:0] h_q, c_q, y_q;

  logic signed [15:0] hp1, cp1;
  logic signed [31:0] prod_pi, prod_pf;
  logic signed [15:0] gi2, gf2, go7;
  logic signed [22:0] csum;
  logic signed [15:0] cn5;
  logic signed [31:0] prod_h;
  logic signed [15:0] hn9;

  // stage enables, back from the output register
  always_comb begin
    en[NumStages+1] = !out_valid_q || !out_stall_i;
    for (int k = NumStages; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_range = 32'(in_req_i.entry_index) < EntryCount;

  // interlock on an entry still being updated
  always_comb begin
    hazard = 1'b0;
    if (!in_req_i.first_step && in_range) begin
      if (v_q[1] && s1_q.active && s1_range_q && s1_q.entry_index == in_req_i.entry_index)
        hazard = 1'b1;
      for (int k = 2; k <= NumStages; k++) begin
        if (v_q[k] && ctl_q[k].wr && ctl_q[k].idx == in_req_i.entry_index)
          hazard = 1'b1;
      end
    end
  end

  assign in_stall_o = !en[1] || hazard;
  assign accept     = in_valid_i && !in_stall_o;

  // store read
  assign rd_o.en  = accept && !in_req_i.first_step && in_range;
  assign rd_o.idx = in_req_i.entry_index;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en[1]) v_q[1] <= accept;
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
      if (en[NumStages+1]) out_valid_q <= v_q[NumStages];
    end
  end

  // stage 1: previous state select and peephole products
  always_comb begin
    if (s1_q.first_step) begin
      hp1 = s1_q.init_h;
      cp1 = s1_q.init_c;
    end else if (s1_range_q) begin
      hp1 = rd_h_i;
      cp1 = rd_c_i;
    end else begin
      hp1 = '0;
      cp1 = '0;
    end
    prod_pi       = s1_q.peep_i * cp1;
    prod_pf       = s1_q.peep_f * cp1;
    s1_ctl.active = s1_q.active;
    s1_ctl.wr     = s1_q.active && s1_range_q;
    s1_ctl.idx    = s1_q.entry_index;
    s1_ctl.h_prev = hp1;
    s1_ctl.c_prev = cp1;
  end

  // stage 2: peephole sums
  assign gi2 = use_peephole_i ? lcu_pkg::peep_add(s2_gi_q, s2_pi_q) : s2_gi_q;
  assign gf2 = use_peephole_i ? lcu_pkg::peep_add(s2_gf_q, s2_pf_q) : s2_gf_q;

  // stage 5: new cell value
  assign csum = 23'(lcu_pkg::qround(s5_fc_q)) + 23'(lcu_pkg::qround(s5_ig_q));
  assign cn5  = lcu_pkg::sat16(24'(csum));

  // stage 7: output gate peephole sum
  assign go7 = use_peephole_i ? lcu_pkg::peep_add(s7_go_q, s7_po_q) : s7_go_q;

  // stage 9: new hidden value
  assign prod_h = s9_ot_q * s9_tc_q;
  assign hn9    = lcu_pkg::sat16(24'(lcu_pkg::qround(prod_h)));

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en[1] && accept) begin
      s1_q       <= in_req_i;
      s1_range_q <= in_range;
    end
    if (en[2]) begin
      ctl_q[2] <= s1_ctl;
      s2_gi_q  <= s1_q.gate_i;
      s2_gf_q  <= s1_q.gate_f;
      s2_go_q  <= s1_q.gate_o;
      s2_gc_q  <= s1_q.gate_c;
      s2_po_q  <= s1_q.peep_o;
      s2_pi_q  <= prod_pi;
      s2_pf_q  <= prod_pf;
    end
    if (en[3]) begin
      ctl_q[3] <= ctl_q[2];
      s3_gi_q  <= gi2;
      s3_gf_q  <= gf2;
      s3_go_q  <= s2_go_q;
      s3_gc_q  <= s2_gc_q;
      s3_po_q  <= s2_po_q;
    end
    if (en[4]) begin
      ctl_q[4] <= ctl_q[3];
      s4_it_q  <= lcu_pkg::sig_q(s3_gi_q);
      s4_ft_q  <= lcu_pkg::sig_q(s3_gf_q);
      s4_ct_q  <= lcu_pkg::tanh_q(s3_gc_q);
      s4_go_q  <= s3_go_q;
      s4_po_q  <= s3_po_q;
    end
    if (en[5]) begin
      ctl_q[5] <= ctl_q[4];
      s5_fc_q  <= s4_ft_q * ctl_q[4].c_prev;
      s5_ig_q  <= s4_it_q * s4_ct_q;
      s5_go_q  <= s4_go_q;
      s5_po_q  <= s4_po_q;
    end
    if (en[6]) begin
      ctl_q[6] <= ctl_q[5];
      s6_cn_q  <= cn5;
      s6_go_q  <= s5_go_q;
      s6_po_q  <= s5_po_q;
    end
    if (en[7]) begin
      ctl_q[7] <= ctl_q[6];
      s7_cn_q  <= s6_cn_q;
      s7_go_q  <= s6_go_q;
      s7_po_q  <= s6_po_q * s6_cn_q;
    end
    if (en[8]) begin
      ctl_q[8] <= ctl_q[7];
      s8_cn_q  <= s7_cn_q;
      s8_go_q  <= go7;
    end
    if (en[9]) begin
      ctl_q[9] <= ctl_q[8];
      s9_cn_q  <= s8_cn_q;
      s9_ot_q  <= lcu_pkg::sig_q(s8_go_q);
      s9_tc_q  <= lcu_pkg::tanh_q(s8_cn_q);
    end
    if (en[NumStages+1]) begin
      if (ctl_q[9].active) begin
        h_q <= hn9;
        c_q <= s9_cn_q;
        y_q <= hn9;
      end else begin
        h_q <= ctl_q[9].h_prev;
        c_q <= ctl_q[9].c_prev;
        y_q <= '0;
      end
    end
  end

  // write-back as the request enters the output register
  assign wr_o.en  = en[NumStages+1] && v_q[NumStages] && ctl_q[9].wr;
  assign wr_o.idx = ctl_q[9].idx;
  assign wr_o.c   = s9_cn_q;
  assign wr_o.h   = hn9;

  assign out_valid_o = out_valid_q;
  assign h_out_o     = h_q;
  assign c_out_o     = c_q;
  assign y_out_o     = y_q;

endmodule

// ===== rtl/lstm_cell_update_unit.sv =====
// -----------------------------------------------------------------------------
// lstm_cell_update_unit
// LSTM element stage with optional peepholes: per-entry cell and hidden
// state in memory, gate activations and state update in a 10-stage pipeline.
// -----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  input   | in_valid_i / in_stall_o| entry_index_i .. peep_f_i
//  output  | out_valid_o/out_stall_i| h_out_o, c_out_o, y_out_o
//  config  | cfg_we_i               | cfg_wdata_i (use_peephole)
//
//  One request per cycle while neither the interlock nor an output stall holds
//  the input. A request that reads an entry still being updated by an earlier
//  request waits until that write-back lands (store read interlock).
//  Reset clears the pipeline valids and the peephole enable; the stores are
//  not cleared. Output stall holds the result and fills bubbles behind it.
module lstm_cell_update_unit #(
  parameter int unsigned HiddenMax = lcu_pkg::HiddenMaxDefault,
  parameter int unsigned BatchMax  = lcu_pkg::BatchMaxDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [10:0]        entry_index_i,
  input  logic               first_step_i,
  input  logic               active_i,
  input  logic signed [15:0] init_h_i,
  input  logic signed [15:0] init_c_i,
  input  logic signed [15:0] gate_i_i,
  input  logic signed [15:0] gate_o_i,
  input  logic signed [15:0] gate_f_i,
  input  logic signed [15:0] gate_c_i,
  input  logic signed [15:0] peep_i_i,
  input  logic signed [15:0] peep_o_i,
  input  logic signed [15:0] peep_f_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] h_out_o,
  output logic signed [15:0] c_out_o,
  output logic signed [15:0] y_out_o
);

  logic               use_peephole_q;
  lcu_pkg::in_req_t   in_req;
  lcu_pkg::rd_req_t   rd_req;
  lcu_pkg::wr_req_t   wr_req;
  logic signed [15:0] rd_c;
  logic signed [15:0] rd_h;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_peephole_q <= 1'b0;
    end else if (cfg_we_i) begin
      use_peephole_q <= cfg_wdata_i;
    end
  end

  // input request bundle
  always_comb begin
    in_req.first_step  = first_step_i;
    in_req.active      = active_i;
    in_req.entry_index = entry_index_i;
    in_req.init_h      = init_h_i;
    in_req.init_c      = init_c_i;
    in_req.gate_i      = gate_i_i;
    in_req.gate_o      = gate_o_i;
    in_req.gate_f      = gate_f_i;
    in_req.gate_c      = gate_c_i;
    in_req.peep_i      = peep_i_i;
    in_req.peep_o      = peep_o_i;
    in_req.peep_f      = peep_f_i;
  end

  lcu_store #(
    .HiddenMax (HiddenMax),
    .BatchMax  (BatchMax)
  ) u_store (
    .clk_i  (clk_i),
    .rd_i   (rd_req),
    .wr_i   (wr_req),
    .rd_c_o (rd_c),
    .rd_h_o (rd_h)
  );

  lcu_pipe #(
    .HiddenMax (HiddenMax),
    .BatchMax  (BatchMax)
  ) u_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .use_peephole_i (use_peephole_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_req_i       (in_req),
    .rd_o           (rd_req),
    .rd_c_i         (rd_c),
    .rd_h_i         (rd_h),
    .wr_o           (wr_req),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .h_out_o        (h_out_o),
    .c_out_o        (c_out_o),
    .y_out_o        (y_out_o)
  );

endmodule

// ===== bench/lstm_cell_update_unit_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lstm_cell_update_unit_tb
// Drives LSTM cell requests with random gaps and output stalls, predicts
// h, c and y per request with a fixed-point cell model of its own and checks
// every result in order, across several peephole settings.
// -----------------------------------------------------------------------------
module lstm_cell_update_unit_tb;

  typedef struct packed {
    logic signed [15:0] h;
    logic signed [15:0] c;
    logic signed [15:0] y;
  } cell_res_t;

  localparam int WatchLimit = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  lcu_pkg::in_req_t cur_req = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] h_out_o, c_out_o, y_out_o;

  // request and expectation queues
  lcu_pkg::in_req_t pending_reqs[$];
  cell_res_t        expected_cells[$];
  int               mismatches = 0;
  bit               peephole_on = 1'b0;
  bit               no_idle = 1'b0;

  // model state of the cell and hidden stores
  logic signed [15:0] cell_mem[2048];
  logic signed [15:0] hidden_mem[2048];
  bit                 entry_written[2048];
  int                 entry_pool[16];

  int sig_knots[17] = '{0, 1, 3, 7, 18, 49, 122, 275, 512, 749, 902, 975, 1006,
                        1017, 1021, 1023, 1024};
  int tanh_knots[17] = '{-1024, -1022, -1019, -1010, -987, -927, -780, -473, 0,
                         473, 780, 927, 987, 1010, 1019, 1022, 1024};

  lstm_cell_update_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .entry_index_i(cur_req.entry_index), .first_step_i(cur_req.first_step),
    .active_i(cur_req.active), .init_h_i(cur_req.init_h), .init_c_i(cur_req.init_c),
    .gate_i_i(cur_req.gate_i), .gate_o_i(cur_req.gate_o), .gate_f_i(cur_req.gate_f),
    .gate_c_i(cur_req.gate_c), .peep_i_i(cur_req.peep_i), .peep_o_i(cur_req.peep_o),
    .peep_f_i(cur_req.peep_f), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .h_out_o(h_out_o), .c_out_o(c_out_o), .y_out_o(y_out_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // fixed-point helpers
  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint q_product(longint a, longint b);
    return (a * b + 512) >>> 10;
  endfunction

  function automatic int sigmoid_pwl(int x);
    int u;
    int k;
    int fr;
    if (x <= -8192) return 0;
    if (x >= 8192) return 1024;
    u = x + 8192;
    k = u / 1024;
    fr = u % 1024;
    return sig_knots[k] + ((sig_knots[k+1] - sig_knots[k]) * fr + 512) / 1024;
  endfunction

  function automatic int tanh_pwl(int x);
    int u;
    int k;
    int fr;
    if (x <= -4096) return -1024;
    if (x >= 4096) return 1024;
    u = x + 4096;
    k = u / 512;
    fr = u % 512;
    return tanh_knots[k] + ((tanh_knots[k+1] - tanh_knots[k]) * fr + 256) / 512;
  endfunction

  function automatic int peephole_gate(int g, int w, int c);
    return int'(clamp16(longint'(g) + clamp16(q_product(w, c))));
  endfunction

  // one cell step: computes the result and, for an active request, updates the stores
  function automatic cell_res_t cell_step(lcu_pkg::in_req_t r);
    cell_res_t res;
    int h_prev, c_prev, gi, gf, go, it, ft, ct, ot, c_new, h_new;
    if (r.first_step) begin
      h_prev = r.init_h;
      c_prev = r.init_c;
    end else begin
      h_prev = hidden_mem[r.entry_index];
      c_prev = cell_mem[r.entry_index];
    end
    if (r.active) begin
      gi = r.gate_i;
      gf = r.gate_f;
      go = r.gate_o;
      if (peephole_on) begin
        gi = peephole_gate(gi, r.peep_i, c_prev);
        gf = peephole_gate(gf, r.peep_f, c_prev);
      end
      it = sigmoid_pwl(gi);
      ft = sigmoid_pwl(gf);
      ct = tanh_pwl(r.gate_c);
      c_new = int'(clamp16(q_product(ft, c_prev) + q_product(it, ct)));
      if (peephole_on) go = peephole_gate(go, r.peep_o, c_new);
      ot = sigmoid_pwl(go);
      h_new = int'(clamp16(q_product(ot, tanh_pwl(c_new))));
      cell_mem[r.entry_index] = c_new[15:0];
      hidden_mem[r.entry_index] = h_new[15:0];
      res = '{h_new[15:0], c_new[15:0], h_new[15:0]};
    end else begin
      res = '{h_prev[15:0], c_prev[15:0], 16'sd0};
    end
    return res;
  endfunction

  // report one mismatch
  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // mostly in the active range of the tables, sometimes full range
  function automatic logic signed [15:0] rand_q();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 18000)) - 9000);
  endfunction

  function automatic lcu_pkg::in_req_t rand_req(int idx, bit first, bit act);
    lcu_pkg::in_req_t r;
    r.entry_index = idx[10:0];
    r.first_step = first;
    r.active = act;
    r.init_h = rand_q();
    r.init_c = ($urandom_range(0, 7) == 0) ? 16'($urandom) : rand_q();
    r.gate_i = rand_q();
    r.gate_o = rand_q();
    r.gate_f = rand_q();
    r.gate_c = rand_q();
    r.peep_i = rand_q();
    r.peep_o = rand_q();
    r.peep_f = rand_q();
    return r;
  endfunction

  // queue a request, never reading an entry that was never written
  task automatic queue_req(lcu_pkg::in_req_t r);
    if (!entry_written[r.entry_index]) r.first_step = 1'b1;
    if (r.active) entry_written[r.entry_index] = 1'b1;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_random(int count);
    lcu_pkg::in_req_t r;
    int idx;
    repeat (count) begin
      if ($urandom_range(0, 9) < 8) begin
        // sequences over a small set of entries
        idx = entry_pool[$urandom_range(0, 15)];
        r = rand_req(idx, $urandom_range(0, 7) == 0, $urandom_range(0, 7) != 0);
      end else begin
        r = rand_req($urandom_range(0, 2047), $urandom_range(0, 1), $urandom_range(0, 1));
      end
      queue_req(r);
    end
  endtask

  task automatic queue_directed();
    lcu_pkg::in_req_t r;
    // extremes of all fields, first step, active
    r = '{1'b1, 1'b1, 11'd2047, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    queue_req(r);
    r = '{1'b1, 1'b1, 11'd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    queue_req(r);
    // cell overflow: forget near one on a full cell plus positive candidate
    r = '{1'b1, 1'b1, 11'd5, 16'sd0, 16'sh7fff, 16'sd9000, 16'sd9000, 16'sd9000,
          16'sd9000, 16'sd0, 16'sd0, 16'sd0};
    queue_req(r);
    r.init_c = 16'sh8000;
    r.gate_c = -16'sd9000;
    queue_req(r);
    // continue from the stored state, then pass it through while inactive
    r = '{1'b0, 1'b1, 11'd5, 16'sd0, 16'sd0, 16'sd100, -16'sd200, 16'sd300,
          16'sd400, 16'sd1024, -16'sd1024, 16'sd512};
    queue_req(r);
    r.active = 1'b0;
    queue_req(r);
    // inactive first step passes the initial values through
    r = '{1'b1, 1'b0, 11'd7, -16'sd1234, 16'sd4321, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, 16'sd0};
    queue_req(r);
    // peephole sums saturating both ways
    r = '{1'b1, 1'b1, 11'd9, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
          16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    queue_req(r);
    r = '{1'b1, 1'b1, 11'd9, 16'sd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
          16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    queue_req(r);
    // knots and table edges
    r = '{1'b1, 1'b1, 11'd11, 16'sd0, 16'sd1024, -16'sd8192, 16'sd8191, -16'sd8191,
          -16'sd4096, 16'sd0, 16'sd0, 16'sd0};
    queue_req(r);
    r = '{1'b1, 1'b1, 11'd11, 16'sd0, -16'sd1024, 16'sd8192, -16'sd8193, 16'sd1023,
          16'sd4095, 16'sd0, 16'sd0, 16'sd0};
    queue_req(r);
    r = '{1'b0, 1'b1, 11'd11, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          -16'sd4095, 16'sd3, -16'sd5, 16'sd7};
    queue_req(r);
  endtask

  // wait until everything has come back, then let the pipeline drain
  // (sampled at the falling edge, once the driver has settled)
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_cells.size() != 0)
      @(negedge clk_i);
    repeat (15) @(posedge clk_i);
  endtask

  task automatic write_peephole(bit v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    peephole_on = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // request driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    logic             nxt_valid;
    lcu_pkg::in_req_t nxt_req;
    nxt_valid = in_valid_i;
    nxt_req = cur_req;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_cells.push_back(cell_step(cur_req));
        nxt_valid = 1'b0;
        in_gap = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_reqs.size() != 0) begin
          nxt_req = pending_reqs.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    in_valid_i <= nxt_valid;
    cur_req <= nxt_req;
  end

  // result monitor with random stalls
  int out_hold = 0;
  always @(posedge clk_i) begin
    cell_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_cells.size() == 0) begin
          $display("unexpected result h %h c %h y %h", h_out_o, c_out_o, y_out_o);
          mismatches++;
        end else begin
          want = expected_cells.pop_front();
          if (h_out_o !== want.h) report_mismatch("h_out", h_out_o, want.h);
          if (c_out_o !== want.c) report_mismatch("c_out", c_out_o, want.c);
          if (y_out_o !== want.y) report_mismatch("y_out", y_out_o, want.y);
        end
        out_hold = no_idle ? 0 : $urandom_range(0, 10);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall_i <= (out_hold > 0);
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("lstm_cell_update_unit_tb: errors");
      $finish;
    end
  end

  // phases
  initial begin
    foreach (entry_pool[i]) entry_pool[i] = $urandom_range(0, 2047);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    wait_idle();
    write_peephole(1'b1);
    queue_directed();
    queue_random(200);
    wait_idle();
    write_peephole(1'b0);
    no_idle = 1'b1;
    queue_random(200);
    wait_idle();
    no_idle = 1'b0;
    write_peephole(1'b1);
    queue_random(200);
    wait_idle();
    write_peephole(1'b0);
    queue_random(180);
    wait_idle();
    if (mismatches == 0 && expected_cells.size() == 0)
      $display("lstm_cell_update_unit_tb: clean");
    else
      $display("lstm_cell_update_unit_tb: errors");
    $finish;
  end

endmodule
